>>> rtl/itgd_pkg.sv
// Package for the tiled grid downsampler: shared constants, codes and types.
// No dependencies; imported by every module of the block.
`default_nettype none

package itgd_pkg;

  // Fixed field widths
  localparam int DIM_W      = 11;  // image width / height register
  localparam int FACT_W     = 4;   // tile factor register
  localparam int PIX_W      = 32;
  localparam int ADDR_W     = 20;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;
  localparam int DIM_MAX    = (1 << DIM_W) - 1;

  // Divider step counter walks the dividend bits
  localparam int DIV_CNT_W  = $clog2(DIM_W);

  // Job queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_FACTOR = 2'd2;

  typedef enum logic [1:0] {
    CFG_IDLE,
    CFG_DIV,
    CFG_COMMIT
  } cfg_state_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_ROW,
    BK_EMIT
  } back_state_t;

  // Configuration status seen by the datapath
  typedef struct packed {
    logic busy;
    logic tiling_ok;
  } cfg_status_t;

  // Job queue status
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

`default_nettype wire

>>> rtl/itgd_cfg.sv
// Configuration registers and tile geometry derivation (serial divider).
// Depends on itgd_pkg.
`default_nettype none

module itgd_cfg #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int MAX_FACTOR = 8,
  parameter int XD_W       = 11,
  parameter int YD_W       = 11,
  parameter int TILE_W     = 3
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [itgd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [itgd_pkg::CFG_DATA_W-1:0]  cfg_data,
  output logic [itgd_pkg::DIM_W-1:0]            width,
  output logic [itgd_pkg::DIM_W-1:0]            height,
  output logic [itgd_pkg::FACT_W-1:0]           factor,
  output logic [XD_W-1:0]                       base_w,
  output logic [TILE_W-1:0]                     extra_w,
  output logic [YD_W-1:0]                       base_h,
  output logic [TILE_W-1:0]                     extra_h,
  output itgd_pkg::cfg_status_t                 status
);
  import itgd_pkg::*;

  localparam logic [DIM_W+1:0]  MAX_W_L = (DIM_W+2)'(MAX_WIDTH);
  localparam logic [DIM_W+1:0]  MAX_H_L = (DIM_W+2)'(MAX_HEIGHT);
  localparam logic [FACT_W-1:0] MAX_F_L = FACT_W'(MAX_FACTOR);

  cfg_state_t             state_r, state_nxt;
  logic [DIM_W-1:0]       width_r, width_nxt;
  logic [DIM_W-1:0]       height_r, height_nxt;
  logic [FACT_W-1:0]      factor_r, factor_nxt;
  logic [DIV_CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [FACT_W-1:0]      rem_w_r, rem_w_nxt, rem_h_r, rem_h_nxt;
  logic [DIM_W-1:0]       q_w_r, q_w_nxt, q_h_r, q_h_nxt;
  logic [XD_W-1:0]        base_w_r, base_w_nxt;
  logic [TILE_W-1:0]      extra_w_r, extra_w_nxt;
  logic [YD_W-1:0]        base_h_r, base_h_nxt;
  logic [TILE_W-1:0]      extra_h_r, extra_h_nxt;
  logic                   ok_r, ok_nxt;

  logic [FACT_W:0]        trial_w, trial_h, div_ext;
  logic                   ge_w, ge_h, ok_calc, cfg_fire;

  // One restoring-division step for each dimension
  always_comb begin
    div_ext = {1'b0, factor_r};
    trial_w = {rem_w_r, width_r[cnt_r]};
    trial_h = {rem_h_r, height_r[cnt_r]};
    ge_w    = trial_w >= div_ext;
    ge_h    = trial_h >= div_ext;
    ok_calc = (factor_r != '0) && (factor_r <= MAX_F_L) &&
              ({2'b00, width_r} <= MAX_W_L) && ({2'b00, height_r} <= MAX_H_L) &&
              (q_w_r != '0) && (q_h_r != '0);
  end

  assign cfg_ready = (state_r == CFG_IDLE);
  assign cfg_fire  = cfg_valid && cfg_ready;

  // Register writes, divider sequencing and commit
  always_comb begin
    state_nxt   = state_r;
    width_nxt   = width_r;
    height_nxt  = height_r;
    factor_nxt  = factor_r;
    cnt_nxt     = cnt_r;
    rem_w_nxt   = rem_w_r;
    rem_h_nxt   = rem_h_r;
    q_w_nxt     = q_w_r;
    q_h_nxt     = q_h_r;
    base_w_nxt  = base_w_r;
    extra_w_nxt = extra_w_r;
    base_h_nxt  = base_h_r;
    extra_h_nxt = extra_h_r;
    ok_nxt      = ok_r;
    unique case (state_r)
      CFG_IDLE: begin
        if (cfg_fire) begin
          unique case (cfg_index)
            CFG_IDX_WIDTH:  width_nxt  = cfg_data[DIM_W-1:0];
            CFG_IDX_HEIGHT: height_nxt = cfg_data[DIM_W-1:0];
            CFG_IDX_FACTOR: factor_nxt = cfg_data[FACT_W-1:0];
            default: ;
          endcase
          cnt_nxt   = DIV_CNT_W'(DIM_W - 1);
          rem_w_nxt = '0;
          rem_h_nxt = '0;
          q_w_nxt   = '0;
          q_h_nxt   = '0;
          state_nxt = CFG_DIV;
        end
      end
      CFG_DIV: begin
        rem_w_nxt = ge_w ? FACT_W'(trial_w - div_ext) : trial_w[FACT_W-1:0];
        rem_h_nxt = ge_h ? FACT_W'(trial_h - div_ext) : trial_h[FACT_W-1:0];
        q_w_nxt   = {q_w_r[DIM_W-2:0], ge_w};
        q_h_nxt   = {q_h_r[DIM_W-2:0], ge_h};
        if (cnt_r == '0) begin
          state_nxt = CFG_COMMIT;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      CFG_COMMIT: begin
        ok_nxt      = ok_calc;
        base_w_nxt  = ok_calc ? XD_W'(q_w_r) : '0;
        base_h_nxt  = ok_calc ? YD_W'(q_h_r) : '0;
        extra_w_nxt = ok_calc ? TILE_W'(rem_w_r) : '0;
        extra_h_nxt = ok_calc ? TILE_W'(rem_h_r) : '0;
        state_nxt   = CFG_IDLE;
      end
      default: state_nxt = CFG_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= CFG_IDLE;
      width_r   <= '0;
      height_r  <= '0;
      factor_r  <= FACT_W'(1);
      base_w_r  <= '0;
      extra_w_r <= '0;
      base_h_r  <= '0;
      extra_h_r <= '0;
      ok_r      <= 1'b0;
      cnt_r     <= '0;
    end else begin
      state_r   <= state_nxt;
      width_r   <= width_nxt;
      height_r  <= height_nxt;
      factor_r  <= factor_nxt;
      base_w_r  <= base_w_nxt;
      extra_w_r <= extra_w_nxt;
      base_h_r  <= base_h_nxt;
      extra_h_r <= extra_h_nxt;
      ok_r      <= ok_nxt;
      cnt_r     <= cnt_nxt;
    end
  end

  // Divider datapath
  always_ff @(posedge clk) begin
    rem_w_r <= rem_w_nxt;
    rem_h_r <= rem_h_nxt;
    q_w_r   <= q_w_nxt;
    q_h_r   <= q_h_nxt;
  end

  assign width            = width_r;
  assign height           = height_r;
  assign factor           = factor_r;
  assign base_w           = base_w_r;
  assign extra_w          = extra_w_r;
  assign base_h           = base_h_r;
  assign extra_h          = extra_h_r;
  assign status.busy      = (state_r != CFG_IDLE);
  assign status.tiling_ok = ok_r;

endmodule

`default_nettype wire

>>> rtl/itgd_front.sv
// Front end: accepts pixels, tracks source position, classifies each pixel
// and pushes write jobs into the queue. Depends on itgd_pkg.
`default_nettype none

module itgd_front #(
  parameter int XP_W   = 10,
  parameter int YP_W   = 10,
  parameter int XD_W   = 11,
  parameter int YD_W   = 11,
  parameter int TILE_W = 3,
  parameter int JOB_W  = 1 + 32 + 10 + 10 + 6
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [itgd_pkg::PIX_W-1:0]     in_pixel_in,
  input  wire logic                           in_frame_start,
  input  wire logic [itgd_pkg::DIM_W-1:0]     width,
  input  wire logic [itgd_pkg::DIM_W-1:0]     height,
  input  wire logic [itgd_pkg::FACT_W-1:0]    factor,
  input  wire logic [XD_W-1:0]                base_w,
  input  wire logic [TILE_W-1:0]              extra_w,
  input  wire logic [YD_W-1:0]                base_h,
  input  wire logic [TILE_W-1:0]              extra_h,
  input  wire itgd_pkg::cfg_status_t          cfg_status,
  input  wire itgd_pkg::q_status_t            q_status,
  output logic                                q_push,
  output logic [JOB_W-1:0]                    q_wdata
);
  import itgd_pkg::*;

  logic [XP_W-1:0]   col_r, col_nxt, sx_r, sx_nxt;
  logic [YP_W-1:0]   row_r, row_nxt, sy_r, sy_nxt;
  logic [TILE_W-1:0] cph_r, cph_nxt, rph_r, rph_nxt;

  // Position after an optional frame restart
  logic [XP_W-1:0]   col_c, sx_c;
  logic [YP_W-1:0]   row_c, sy_c;
  logic [TILE_W-1:0] cph_c, rph_c;

  logic              in_fire, sampled, rows_any, cols_any;
  logic [TILE_W-1:0] r_last, c_last, n_last;
  logic [DIM_W:0]    col_inc, row_inc;
  logic [FACT_W-1:0] cph_inc, rph_inc;

  assign in_ready = !cfg_status.busy && !q_status.full;
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    col_c = in_frame_start ? '0 : col_r;
    row_c = in_frame_start ? '0 : row_r;
    cph_c = in_frame_start ? '0 : cph_r;
    rph_c = in_frame_start ? '0 : rph_r;
    sx_c  = in_frame_start ? '0 : sx_r;
    sy_c  = in_frame_start ? '0 : sy_r;
  end

  // Classify: which tile rows and columns receive this sample
  always_comb begin
    n_last   = TILE_W'(factor - FACT_W'(1));
    sampled  = (cph_c == '0) && (rph_c == '0);
    rows_any = 1'b1;
    cols_any = 1'b1;
    if (YD_W'(sy_c) < base_h) begin
      r_last = n_last;
    end else if ((YD_W'(sy_c) == base_h) && (extra_h != '0)) begin
      r_last = extra_h - 1'b1;
    end else begin
      r_last   = '0;
      rows_any = 1'b0;
    end
    if (XD_W'(sx_c) < base_w) begin
      c_last = n_last;
    end else if ((XD_W'(sx_c) == base_w) && (extra_w != '0)) begin
      c_last = extra_w - 1'b1;
    end else begin
      c_last   = '0;
      cols_any = 1'b0;
    end
  end

  assign q_push  = in_fire &&
                   (!cfg_status.tiling_ok || (sampled && rows_any && cols_any));
  assign q_wdata = {!cfg_status.tiling_ok, in_pixel_in, sx_c, sy_c, r_last, c_last};

  // Raster advance with phase wrap at the tile factor
  always_comb begin
    col_inc = (DIM_W+1)'(col_c) + 1'b1;
    row_inc = (DIM_W+1)'(row_c) + 1'b1;
    cph_inc = FACT_W'(cph_c) + 1'b1;
    rph_inc = FACT_W'(rph_c) + 1'b1;
    col_nxt = col_r;
    row_nxt = row_r;
    cph_nxt = cph_r;
    rph_nxt = rph_r;
    sx_nxt  = sx_r;
    sy_nxt  = sy_r;
    if (in_fire) begin
      col_nxt = col_c;
      row_nxt = row_c;
      cph_nxt = cph_c;
      rph_nxt = rph_c;
      sx_nxt  = sx_c;
      sy_nxt  = sy_c;
      if (cfg_status.tiling_ok) begin
        if (col_inc >= (DIM_W+1)'(width)) begin
          col_nxt = '0;
          cph_nxt = '0;
          sx_nxt  = '0;
          if (row_inc >= (DIM_W+1)'(height)) begin
            row_nxt = '0;
            rph_nxt = '0;
            sy_nxt  = '0;
          end else begin
            row_nxt = YP_W'(row_inc);
            if (rph_inc >= factor) begin
              rph_nxt = '0;
              sy_nxt  = sy_c + 1'b1;
            end else begin
              rph_nxt = TILE_W'(rph_inc);
            end
          end
        end else begin
          col_nxt = XP_W'(col_inc);
          if (cph_inc >= factor) begin
            cph_nxt = '0;
            sx_nxt  = sx_c + 1'b1;
          end else begin
            cph_nxt = TILE_W'(cph_inc);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      cph_r <= '0;
      rph_r <= '0;
      sx_r  <= '0;
      sy_r  <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      cph_r <= cph_nxt;
      rph_r <= rph_nxt;
      sx_r  <= sx_nxt;
      sy_r  <= sy_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/itgd_queue.sv
// Short FIFO of write jobs between the front and back ends.
// Depends on itgd_pkg for depth and status type.
`default_nettype none

module itgd_queue #(
  parameter int JOB_W = 59
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [JOB_W-1:0] wdata,
  input  wire logic             pop,
  output logic [JOB_W-1:0]      rdata,
  output itgd_pkg::q_status_t   status
);
  import itgd_pkg::*;

  logic [JOB_W-1:0]  slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QPTR_W:0]   count_r;

  assign status.full  = (count_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign status.empty = (count_r == '0);
  assign rdata        = slot_r[rd_ptr_r];

  // Pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_r + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
    end
  end

  // Job storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

`default_nettype wire

>>> rtl/itgd_back.sv
// Back end: walks the tile rectangle of each job, forms write addresses
// and drives the registered result channel. Depends on itgd_pkg.
`default_nettype none

module itgd_back #(
  parameter int XP_W   = 10,
  parameter int YP_W   = 10,
  parameter int XD_W   = 11,
  parameter int YD_W   = 11,
  parameter int TILE_W = 3,
  parameter int JOB_W  = 1 + 32 + 10 + 10 + 6
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic [JOB_W-1:0]               job,
  input  wire itgd_pkg::q_status_t            q_status,
  output logic                                q_pop,
  input  wire logic [itgd_pkg::DIM_W-1:0]     width,
  input  wire logic [XD_W-1:0]                base_w,
  input  wire logic [TILE_W-1:0]              extra_w,
  input  wire logic [YD_W-1:0]                base_h,
  input  wire logic [TILE_W-1:0]              extra_h,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [itgd_pkg::ADDR_W-1:0]         out_write_addr,
  output logic [itgd_pkg::PIX_W-1:0]          out_pixel_out,
  output logic                                out_last_write,
  output logic                                out_config_error
);
  import itgd_pkg::*;

  // Job fields
  logic              job_err;
  logic [PIX_W-1:0]  job_pixel;
  logic [XP_W-1:0]   job_x;
  logic [YP_W-1:0]   job_y;
  logic [TILE_W-1:0] job_r_last, job_c_last;

  assign {job_err, job_pixel, job_x, job_y, job_r_last, job_c_last} = job;

  back_state_t       state_r, state_nxt;
  logic [PIX_W-1:0]  pixel_r, pixel_nxt;
  logic [XP_W-1:0]   x_r, x_nxt, col_pos_r, col_pos_nxt;
  logic [YP_W-1:0]   row_pos_r, row_pos_nxt;
  logic [TILE_W-1:0] r_r, r_nxt, c_r, c_nxt, r_last_r, r_last_nxt, c_last_r, c_last_nxt;
  logic [ADDR_W-1:0] row_base_r, row_base_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [ADDR_W-1:0] out_addr_r, out_addr_nxt;
  logic [PIX_W-1:0]  out_pixel_r, out_pixel_nxt;
  logic              out_last_r, out_last_nxt, out_err_r, out_err_nxt;

  logic                  load_ok;
  logic [YP_W+DIM_W-1:0] row_prod;
  logic [XP_W-1:0]       col_step;
  logic [YP_W-1:0]       row_step;

  assign load_ok  = !out_valid_r || out_ready;
  assign row_prod = row_pos_r * width;
  assign col_step = XP_W'(base_w) + XP_W'(c_r < extra_w);
  assign row_step = YP_W'(base_h) + YP_W'(r_r < extra_h);

  // Sequencer: dispatch, row address multiply, one write per cycle unless out_ready stalls
  always_comb begin
    state_nxt     = state_r;
    pixel_nxt     = pixel_r;
    x_nxt         = x_r;
    col_pos_nxt   = col_pos_r;
    row_pos_nxt   = row_pos_r;
    r_nxt         = r_r;
    c_nxt         = c_r;
    r_last_nxt    = r_last_r;
    c_last_nxt    = c_last_r;
    row_base_nxt  = row_base_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_addr_nxt  = out_addr_r;
    out_pixel_nxt = out_pixel_r;
    out_last_nxt  = out_last_r;
    out_err_nxt   = out_err_r;
    q_pop         = 1'b0;
    unique case (state_r)
      BK_IDLE: begin
        if (!q_status.empty) begin
          if (job_err) begin
            if (load_ok) begin
              q_pop         = 1'b1;
              out_valid_nxt = 1'b1;
              out_addr_nxt  = '0;
              out_pixel_nxt = '0;
              out_last_nxt  = 1'b1;
              out_err_nxt   = 1'b1;
            end
          end else begin
            q_pop       = 1'b1;
            pixel_nxt   = job_pixel;
            x_nxt       = job_x;
            col_pos_nxt = job_x;
            row_pos_nxt = job_y;
            r_nxt       = '0;
            c_nxt       = '0;
            r_last_nxt  = job_r_last;
            c_last_nxt  = job_c_last;
            state_nxt   = BK_ROW;
          end
        end
      end
      BK_ROW: begin
        row_base_nxt = ADDR_W'(row_prod);
        state_nxt    = BK_EMIT;
      end
      BK_EMIT: begin
        if (load_ok) begin
          out_valid_nxt = 1'b1;
          out_addr_nxt  = row_base_r + ADDR_W'(col_pos_r);
          out_pixel_nxt = pixel_r;
          out_last_nxt  = (r_r == r_last_r) && (c_r == c_last_r);
          out_err_nxt   = 1'b0;
          if (c_r == c_last_r) begin
            if (r_r == r_last_r) begin
              state_nxt = BK_IDLE;
            end else begin
              r_nxt       = r_r + 1'b1;
              c_nxt       = '0;
              row_pos_nxt = row_pos_r + row_step;
              col_pos_nxt = x_r;
              state_nxt   = BK_ROW;
            end
          end else begin
            c_nxt       = c_r + 1'b1;
            col_pos_nxt = col_pos_r + col_step;
          end
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    pixel_r     <= pixel_nxt;
    x_r         <= x_nxt;
    col_pos_r   <= col_pos_nxt;
    row_pos_r   <= row_pos_nxt;
    r_r         <= r_nxt;
    c_r         <= c_nxt;
    r_last_r    <= r_last_nxt;
    c_last_r    <= c_last_nxt;
    row_base_r  <= row_base_nxt;
    out_addr_r  <= out_addr_nxt;
    out_pixel_r <= out_pixel_nxt;
    out_last_r  <= out_last_nxt;
    out_err_r   <= out_err_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_write_addr   = out_addr_r;
  assign out_pixel_out    = out_pixel_r;
  assign out_last_write   = out_last_r;
  assign out_config_error = out_err_r;

endmodule

`default_nettype wire

>>> rtl/image_tile_grid_downsample.sv
// Tiled grid downsampler top level: configuration, front end, job queue and back end.
// A sampled pixel's first write passes the job queue, the back-end row address state and
// the registered output. Throughput: one pixel accepted per cycle while the 4-entry job
// queue has room and no configuration is being derived; a sampled pixel is written to R
// tile rows of C tile columns. Configuration writes run a serial divide, input held off.
// Reset (sync, active low): position cleared, width 0, height 0, factor 1.
// Depends on itgd_pkg, itgd_cfg, itgd_front, itgd_queue, itgd_back.
`default_nettype none

module image_tile_grid_downsample #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int MAX_FACTOR = 8
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [itgd_pkg::PIX_W-1:0]      in_pixel_in,
  input  wire logic                            in_frame_start,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [itgd_pkg::ADDR_W-1:0]          out_write_addr,
  output logic [itgd_pkg::PIX_W-1:0]           out_pixel_out,
  output logic                                 out_last_write,
  output logic                                 out_config_error,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [itgd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [itgd_pkg::CFG_DATA_W-1:0] cfg_data
);
  import itgd_pkg::*;

  // Usable dimension limits and the widths that follow
  localparam int WLIM   = (MAX_WIDTH < DIM_MAX) ? MAX_WIDTH : DIM_MAX;
  localparam int HLIM   = (MAX_HEIGHT < DIM_MAX) ? MAX_HEIGHT : DIM_MAX;
  localparam int XP_W   = (WLIM > 1) ? $clog2(WLIM) : 1;
  localparam int YP_W   = (HLIM > 1) ? $clog2(HLIM) : 1;
  localparam int XD_W   = $clog2(WLIM + 1);
  localparam int YD_W   = $clog2(HLIM + 1);
  localparam int TILE_W = (MAX_FACTOR > 1) ? $clog2(MAX_FACTOR) : 1;
  localparam int JOB_W  = 1 + PIX_W + XP_W + YP_W + 2 * TILE_W;

  logic [DIM_W-1:0]  width, height;
  logic [FACT_W-1:0] factor;
  logic [XD_W-1:0]   base_w;
  logic [YD_W-1:0]   base_h;
  logic [TILE_W-1:0] extra_w, extra_h;
  cfg_status_t       cfg_status;
  q_status_t         q_status;
  logic              q_push, q_pop;
  logic [JOB_W-1:0]  q_wdata, q_rdata;

  itgd_cfg #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT),
    .MAX_FACTOR(MAX_FACTOR),
    .XD_W      (XD_W),
    .YD_W      (YD_W),
    .TILE_W    (TILE_W)
  ) u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .width    (width),
    .height   (height),
    .factor   (factor),
    .base_w   (base_w),
    .extra_w  (extra_w),
    .base_h   (base_h),
    .extra_h  (extra_h),
    .status   (cfg_status)
  );

  itgd_front #(
    .XP_W  (XP_W),
    .YP_W  (YP_W),
    .XD_W  (XD_W),
    .YD_W  (YD_W),
    .TILE_W(TILE_W),
    .JOB_W (JOB_W)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_pixel_in   (in_pixel_in),
    .in_frame_start(in_frame_start),
    .width         (width),
    .height        (height),
    .factor        (factor),
    .base_w        (base_w),
    .extra_w       (extra_w),
    .base_h        (base_h),
    .extra_h       (extra_h),
    .cfg_status    (cfg_status),
    .q_status      (q_status),
    .q_push        (q_push),
    .q_wdata       (q_wdata)
  );

  itgd_queue #(
    .JOB_W(JOB_W)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .status(q_status)
  );

  itgd_back #(
    .XP_W  (XP_W),
    .YP_W  (YP_W),
    .XD_W  (XD_W),
    .YD_W  (YD_W),
    .TILE_W(TILE_W),
    .JOB_W (JOB_W)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .job             (q_rdata),
    .q_status        (q_status),
    .q_pop           (q_pop),
    .width           (width),
    .base_w          (base_w),
    .extra_w         (extra_w),
    .base_h          (base_h),
    .extra_h         (extra_h),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_write_addr  (out_write_addr),
    .out_pixel_out   (out_pixel_out),
    .out_last_write  (out_last_write),
    .out_config_error(out_config_error)
  );

  // An error result is a lone, marked transaction with no write
  a_err_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_config_error |-> out_last_write && (out_write_addr == '0) &&
                                      (out_pixel_out == '0))
    else $error("error result not marked last or carries a write");

  // No pixel is taken while the geometry is being derived
  a_hold_in_cfg: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_status.busy |-> !in_ready)
    else $error("pixel accepted during configuration derive");

  // The job queue never overflows or underflows
  a_queue_safe: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_status.full && q_push) && !(q_status.empty && q_pop))
    else $error("job queue overflow or underflow");

  // The back end pulls a job only in the cycle after a write sequence closes or when idle
  a_pop_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop && $past(q_pop) |-> out_config_error || $past(out_config_error) ||
                              !$past(out_valid) || $past(out_last_write))
    else $error("job popped while a write sequence is open");

endmodule

`default_nettype wire

>>> verif/image_tile_grid_downsample_test.sv
// Self-checking testbench for image_tile_grid_downsample: directed stimulus rows, then random frames.
// Tile writes are predicted in-bench from the register settings and the raster position.
// Depends on itgd_pkg and the image_tile_grid_downsample RTL.

module image_tile_grid_downsample_test;
  timeunit 1ns;
  timeprecision 1ps;

  import itgd_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;  // unmapped register index
  localparam int SETTLE_CYCLES  = 64;    // drain for pixels that produce no write
  localparam int STALL_LIMIT    = 2000;  // cycles without any transaction
  localparam int RANDOM_PIXELS  = 80;
  localparam int MAX_FACTOR_CFG = 8;
  localparam int MAX_DIM_CFG    = 1024;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [PIX_W-1:0]  pix;
    logic              last;
    logic              err;
  } tile_write_t;

  typedef enum logic [1:0] {ROW_PIXEL, ROW_REG} row_kind_t;
  typedef enum logic [1:0] {CHK_PRED, CHK_ERR, CHK_ADDR} row_check_t;

  typedef struct {
    row_kind_t         kind;
    row_check_t        check;
    logic [CFG_IDX_W-1:0] idx;
    logic [31:0]       val;   // pixel value or register data
    logic              fs;
    logic [ADDR_W-1:0] addr;
  } stim_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [PIX_W-1:0]      in_pixel_in = '0;
  logic                  in_frame_start = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [ADDR_W-1:0]     out_write_addr;
  logic [PIX_W-1:0]      out_pixel_out;
  logic                  out_last_write;
  logic                  out_config_error;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  logic steady = 1'b0;  // no idling on either side while set

  // Predictor state
  int unsigned img_w, img_h, factor;
  int unsigned base_w, extra_w, base_h, extra_h;
  bit          tiling_ok;
  int unsigned src_col, src_row, col_phase, row_phase, samp_col, samp_row;

  tile_write_t tile_writes[$];     // writes caused by the latest pixel
  tile_write_t pending_writes[$];  // writes still owed by the block
  stim_row_t   stim_rows[$];

  int mismatches = 0;
  int n_pixels = 0, n_directed = 0, n_regs = 0, n_writes = 0, n_err = 0;
  int idle_cycles = 0;

  image_tile_grid_downsample DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_pixel_in      (in_pixel_in),
    .in_frame_start   (in_frame_start),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_write_addr   (out_write_addr),
    .out_pixel_out    (out_pixel_out),
    .out_last_write   (out_last_write),
    .out_config_error (out_config_error),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Tile sizes follow the registers; any bad setting disables tiling entirely
  function automatic void derive_tiling();
    tiling_ok = 1'b0;
    base_w = 0; extra_w = 0; base_h = 0; extra_h = 0;
    if (factor < 1 || factor > MAX_FACTOR_CFG || img_w > MAX_DIM_CFG || img_h > MAX_DIM_CFG)
      return;
    if (img_w / factor == 0 || img_h / factor == 0)
      return;
    base_w = img_w / factor;
    extra_w = img_w % factor;
    base_h = img_h / factor;
    extra_h = img_h % factor;
    tiling_ok = 1'b1;
  endfunction

  function automatic void clear_position();
    src_col = 0; src_row = 0;
    col_phase = 0; row_phase = 0;
    samp_col = 0; samp_row = 0;
  endfunction

  // Raster step with wrap at end of row and end of frame
  function automatic void step_position();
    if (src_col + 1 >= img_w) begin
      src_col = 0; col_phase = 0; samp_col = 0;
      if (src_row + 1 >= img_h) begin
        src_row = 0; row_phase = 0; samp_row = 0;
      end else begin
        src_row++;
        if (row_phase + 1 >= factor) begin
          row_phase = 0;
          samp_row++;
        end else begin
          row_phase++;
        end
      end
    end else begin
      src_col++;
      if (col_phase + 1 >= factor) begin
        col_phase = 0;
        samp_col++;
      end else begin
        col_phase++;
      end
    end
  endfunction

  function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_IDX_WIDTH:  img_w = data;
      CFG_IDX_HEIGHT: img_h = data;
      CFG_IDX_FACTOR: factor = data[FACT_W-1:0];
      default: return;
    endcase
    derive_tiling();
  endfunction

  // Scatter one source pixel into every tile that holds its sampled position
  function automatic void scatter_pixel(input logic [PIX_W-1:0] pix, input logic fs);
    int unsigned r, c, th, tw, xo, yo;
    longint unsigned a;
    tile_write_t w;
    tile_writes.delete();
    if (fs)
      clear_position();
    if (!tiling_ok) begin
      w = '{addr: '0, pix: '0, last: 1'b1, err: 1'b1};
      tile_writes.push_back(w);
      return;
    end
    if (col_phase == 0 && row_phase == 0) begin
      for (r = 0; r < factor; r++) begin
        th = base_h + ((r < extra_h) ? 1 : 0);
        yo = r * base_h + ((r < extra_h) ? r : extra_h);
        if (samp_row >= th)
          continue;
        for (c = 0; c < factor; c++) begin
          tw = base_w + ((c < extra_w) ? 1 : 0);
          xo = c * base_w + ((c < extra_w) ? c : extra_w);
          if (samp_col >= tw || tile_writes.size() >= 64)
            continue;
          a = longint'(yo + samp_row) * img_w + xo + samp_col;
          w = '{addr: a[ADDR_W-1:0], pix: pix, last: 1'b0, err: 1'b0};
          tile_writes.push_back(w);
        end
      end
      if (tile_writes.size() > 0)
        tile_writes[tile_writes.size()-1].last = 1'b1;
    end
    step_position();
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Stop sending and wait for every owed write
  task automatic hold_until_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_writes.size() != 0)
      @(posedge clk);
  endtask

  // Registers are only touched with the block fully idle
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    hold_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    cfg_valid <= 1'b0;
    apply_reg(idx, data);
    n_regs++;
  endtask

  // One pixel transaction; queues either the typed write or the predicted burst
  task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic fs,
                            input bit typed, input tile_write_t typed_write);
    if (!steady && $urandom_range(0, 99) < 16) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_pixel_in    <= pix;
    in_frame_start <= fs;
    do @(posedge clk); while (!(in_valid && in_ready));
    scatter_pixel(pix, fs);
    n_pixels++;
    if (typed)
      pending_writes.push_back(typed_write);
    else
      foreach (tile_writes[i]) pending_writes.push_back(tile_writes[i]);
  endtask

  function automatic void add_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    stim_rows.push_back('{kind: ROW_REG, check: CHK_PRED, idx: idx, val: val,
                          fs: 1'b0, addr: '0});
  endfunction

  function automatic void add_pix(input logic [31:0] val, input logic fs,
                                  input row_check_t check, input logic [ADDR_W-1:0] addr);
    stim_rows.push_back('{kind: ROW_PIXEL, check: check, idx: '0, val: val,
                          fs: fs, addr: addr});
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : write_monitor
    tile_write_t got, want;
    if (rst_n && out_valid && out_ready) begin
      got = {out_write_addr, out_pixel_out, out_last_write, out_config_error};
      if (pending_writes.size() == 0) begin
        $error("unexpected write transaction: write_addr %0h pixel_out %0h",
               out_write_addr, out_pixel_out);
        mismatches++;
      end else begin
        want = pending_writes.pop_front();
        if (got.addr !== want.addr) begin
          $error("write_addr: expected %0h, got %0h", want.addr, got.addr);
          mismatches++;
        end
        if (got.pix !== want.pix) begin
          $error("pixel_out: expected %0h, got %0h", want.pix, got.pix);
          mismatches++;
        end
        if (got.last !== want.last) begin
          $error("last_write: expected %0b, got %0b", want.last, got.last);
          mismatches++;
        end
        if (got.err !== want.err) begin
          $error("config_error: expected %0b, got %0b", want.err, got.err);
          mismatches++;
        end
        if (want.err)
          n_err++;
        else
          n_writes++;
      end
    end
  end

  // Receiver back-pressure
  always @(posedge clk)
    out_ready <= steady || ($urandom_range(0, 99) >= 16);

  // Watchdog: any transaction on any channel counts as progress
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout: no transaction for %0d cycles, %0d writes outstanding",
               STALL_LIMIT, pending_writes.size());
      $display("** image_tile_grid_downsample: FAILED **");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    stim_row_t   row;
    tile_write_t typed_write;
    int unsigned w, h, f, len, sent;
    int          phase;
    logic        fs;

    // Directed rows: typed writes where the address is obvious
    add_pix(32'hFFFF_FFFF, 1'b1, CHK_ERR, '0);   // reset state: width 0 is invalid
    add_pix(32'h0000_0000, 1'b0, CHK_ERR, '0);
    add_reg(CFG_IDX_SPARE, 32'h7FF);              // unmapped index, no effect
    add_pix(32'h1234_5678, 1'b0, CHK_ERR, '0);
    add_reg(CFG_IDX_WIDTH, 1024);
    add_reg(CFG_IDX_HEIGHT, 1024);
    add_reg(CFG_IDX_FACTOR, 32'h7F1);             // upper data bits dropped, factor 1
    add_pix(32'hFFFF_FFFF, 1'b1, CHK_ADDR, 20'd0);
    add_pix(32'hA5A5_A5A5, 1'b0, CHK_ADDR, 20'd1);
    add_pix(32'h5A5A_5A5A, 1'b1, CHK_ADDR, 20'd0);
    add_reg(CFG_IDX_WIDTH, 2047);                 // over the max width
    add_pix(32'h0000_FFFF, 1'b1, CHK_ERR, '0);
    add_reg(CFG_IDX_WIDTH, 2);
    add_reg(CFG_IDX_HEIGHT, 2);
    add_pix(32'h1111_1111, 1'b1, CHK_ADDR, 20'd0);
    add_pix(32'h2222_2222, 1'b0, CHK_ADDR, 20'd1);  // end of row next
    add_pix(32'h3333_3333, 1'b0, CHK_ADDR, 20'd2);
    add_pix(32'h4444_4444, 1'b0, CHK_ADDR, 20'd3);  // end of frame next
    add_pix(32'h5555_5555, 1'b0, CHK_ADDR, 20'd0);
    add_reg(CFG_IDX_FACTOR, 3);                   // width smaller than factor
    add_pix(32'h6666_6666, 1'b1, CHK_ERR, '0);
    add_reg(CFG_IDX_FACTOR, 0);
    add_pix(32'h7777_7777, 1'b1, CHK_ERR, '0);
    add_reg(CFG_IDX_FACTOR, 15);
    add_pix(32'h8888_8888, 1'b1, CHK_ERR, '0);
    add_reg(CFG_IDX_WIDTH, 16);
    add_reg(CFG_IDX_HEIGHT, 9);
    add_reg(CFG_IDX_FACTOR, 8);                   // full 8x8 grid
    add_pix(32'hDEAD_BEEF, 1'b1, CHK_PRED, '0);
    add_pix(32'hCAFE_F00D, 1'b0, CHK_PRED, '0);   // not sampled
    add_reg(CFG_IDX_FACTOR, 3);
    add_reg(CFG_IDX_WIDTH, 7);
    add_reg(CFG_IDX_HEIGHT, 5);                   // remainder tiles both ways
    add_pix(32'h0F0F_0F0F, 1'b1, CHK_PRED, '0);
    add_pix(32'hF0F0_F0F0, 1'b0, CHK_PRED, '0);
    add_pix(32'h3C3C_3C3C, 1'b0, CHK_PRED, '0);
    add_pix(32'hC3C3_C3C3, 1'b0, CHK_PRED, '0);

    img_w = 0; img_h = 0; factor = 1;
    clear_position();
    derive_tiling();

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part
    foreach (stim_rows[i]) begin
      row = stim_rows[i];
      if (row.kind == ROW_REG) begin
        write_reg(row.idx, row.val[CFG_DATA_W-1:0]);
      end else begin
        case (row.check)
          CHK_ERR:  typed_write = '{addr: '0, pix: '0, last: 1'b1, err: 1'b1};
          CHK_ADDR: typed_write = '{addr: row.addr, pix: row.val, last: 1'b1, err: 1'b0};
          default:  typed_write = '0;
        endcase
        send_pixel(row.val, row.fs, row.check != CHK_PRED, typed_write);
        n_directed++;
      end
    end

    // Random frames: mostly valid tilings, some invalid and some very wide
    sent = 0;
    phase = 0;
    while (sent < RANDOM_PIXELS) begin
      steady <= (phase == 1);
      f = $urandom_range(1, MAX_FACTOR_CFG);
      w = $urandom_range(f, f + 6);
      h = $urandom_range(f, f + 4);
      len = w * h + $urandom_range(0, 3);
      if (len > 48)
        len = $urandom_range(24, 48);
      case ($urandom_range(0, 9))
        0: begin
          case ($urandom_range(0, 4))
            0: f = 0;
            1: f = $urandom_range(MAX_FACTOR_CFG + 1, 15);
            2: w = $urandom_range(MAX_DIM_CFG + 1, DIM_MAX);
            3: h = $urandom_range(MAX_DIM_CFG + 1, DIM_MAX);
            default: w = $urandom_range(0, f - 1);
          endcase
          len = $urandom_range(3, 8);
        end
        1: begin
          w = $urandom_range(MAX_DIM_CFG - 24, MAX_DIM_CFG);
          len = $urandom_range(24, 40);
        end
        default: ;
      endcase
      write_reg(CFG_IDX_WIDTH, CFG_DATA_W'(w));
      write_reg(CFG_IDX_HEIGHT, CFG_DATA_W'(h));
      write_reg(CFG_IDX_FACTOR, CFG_DATA_W'(f));

      // First pixel usually opens a frame; otherwise the old position carries over
      for (int k = 0; k < len && sent < RANDOM_PIXELS; k++) begin
        if (k == 0)
          fs = ($urandom_range(0, 99) < 80);
        else
          fs = ($urandom_range(0, 99) < 3);
        send_pixel($urandom, fs, 1'b0, '0);
        sent++;
        if (sent % 30 == 0)
          hold_until_drained();
      end
      phase++;
    end

    // Drain and let any trailing activity show up
    hold_until_drained();
    steady <= 1'b0;
    repeat (100) @(posedge clk);

    $display("Sent %0d pixel transactions (%0d directed) across %0d register writes.",
             n_pixels, n_directed, n_regs);
    $display("Checked %0d tile writes and %0d config-error results.", n_writes, n_err);
    if (mismatches == 0 && pending_writes.size() == 0)
      $display("** image_tile_grid_downsample: PASSED **");
    else
      $display("** image_tile_grid_downsample: FAILED **");
    $finish;
  end

endmodule
